[sv/spsub_pkg.sv]
package spsub_pkg;

  localparam int MAX_TERMS = 32;

  localparam int COEF_W = 16;
  localparam int EXP_W  = 16;
  localparam int RES_W  = 17;
  localparam int ACT_W  = 2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [EXP_W-1:0]         exp_t;
  typedef logic signed [RES_W-1:0]  res_coef_t;
  typedef logic [ACT_W-1:0]         action_t;

  localparam action_t ACT_LOAD_A  = 2'd0;
  localparam action_t ACT_LOAD_B  = 2'd1;
  localparam action_t ACT_COMPUTE = 2'd2;

endpackage

[sv/spsub_if.sv]
interface spsub_in_if;
  logic                valid;
  logic                ready;
  spsub_pkg::action_t  action;
  spsub_pkg::coef_t    term_coef;
  spsub_pkg::exp_t     term_exp;

  modport source (output valid, output action, output term_coef, output term_exp,
                  input ready);
  modport sink   (input valid, input action, input term_coef, input term_exp,
                  output ready);
endinterface

interface spsub_out_if;
  logic                  valid;
  logic                  ready;
  spsub_pkg::res_coef_t  out_coef;
  spsub_pkg::exp_t       out_exp;
  logic                  out_last;
  logic                  out_empty;

  modport source (output valid, output out_coef, output out_exp, output out_last,
                  output out_empty, input ready);
  modport sink   (input valid, input out_coef, input out_exp, input out_last,
                  input out_empty, output ready);
endinterface

[sv/sparse_polynomial_subtract.sv]
// Channel   Dir  Payload                                  Transfer
// in_if     in   action, term_coef, term_exp              valid & ready
// out_if    out  out_coef, out_exp, out_last, out_empty   valid & ready
//
// A load (A or B) leaves ready high, so loads can go back to back.
// A compute runs merge steps (list RAM read in ST_FETCH, then one pass through
// the shared subtractor in ST_STEP), with steps <= na+nb; the registered RAM read
// comes before each step. Input ready is low throughout.
// An output stall holds the merge at any step while the output register is occupied.
// Reset (synchronous, active low) empties both lists and drops any pending result.
module sparse_polynomial_subtract #(
  parameter int MAX_TERMS = spsub_pkg::MAX_TERMS
) (
  input  logic        clk,
  input  logic        rst_n,
  spsub_in_if.sink    in_if,
  spsub_out_if.source out_if
);

  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int WORD_W = spsub_pkg::COEF_W + spsub_pkg::EXP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_STEP
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      a_cnt_r, b_cnt_r;
  logic [CNT_W-1:0]      ia_r, ib_r;

  // Result held back one step so the final one can carry the last flag.
  logic                  pend_valid_r;
  spsub_pkg::res_coef_t  pend_coef_r;
  spsub_pkg::exp_t       pend_exp_r;

  logic                  out_valid_r;
  spsub_pkg::res_coef_t  out_coef_r;
  spsub_pkg::exp_t       out_exp_r;
  logic                  out_last_r;
  logic                  out_empty_r;

  logic                  in_xfer;
  logic                  a_we, b_we;
  logic [WORD_W-1:0]     wr_word;
  logic [WORD_W-1:0]     a_rdata, b_rdata;

  spsub_pkg::coef_t      a_coef, b_coef;
  spsub_pkg::exp_t       a_exp, b_exp;
  logic                  a_has, b_has;
  logic                  take_a, take_b;
  spsub_pkg::res_coef_t  sub_x, sub_y, diff;
  spsub_pkg::exp_t       res_exp;
  logic                  res_valid;
  logic                  slot_free;
  logic                  out_load;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;

  assign out_if.valid     = out_valid_r;
  assign out_if.out_coef  = out_coef_r;
  assign out_if.out_exp   = out_exp_r;
  assign out_if.out_last  = out_last_r;
  assign out_if.out_empty = out_empty_r;

  // Loads beyond capacity are dropped: no write, no count.
  assign a_we = in_xfer && (in_if.action == spsub_pkg::ACT_LOAD_A)
                && (a_cnt_r < CNT_W'(MAX_TERMS));
  assign b_we = in_xfer && (in_if.action == spsub_pkg::ACT_LOAD_B)
                && (b_cnt_r < CNT_W'(MAX_TERMS));
  assign wr_word = {in_if.term_coef, in_if.term_exp};

  spsub_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_TERMS)
  ) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_cnt_r[IDX_W-1:0]),
    .wdata (wr_word),
    .raddr (ia_r[IDX_W-1:0]),
    .rdata (a_rdata)
  );

  spsub_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_TERMS)
  ) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_cnt_r[IDX_W-1:0]),
    .wdata (wr_word),
    .raddr (ib_r[IDX_W-1:0]),
    .rdata (b_rdata)
  );

  assign a_coef = a_rdata[WORD_W-1:spsub_pkg::EXP_W];
  assign a_exp  = a_rdata[spsub_pkg::EXP_W-1:0];
  assign b_coef = b_rdata[WORD_W-1:spsub_pkg::EXP_W];
  assign b_exp  = b_rdata[spsub_pkg::EXP_W-1:0];

  assign a_has = (ia_r < a_cnt_r);
  assign b_has = (ib_r < b_cnt_r);

  // Pick the side(s) with the larger exponent; equal exponents take both.
  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    priority if (a_has && b_has && (a_exp == b_exp)) begin
      take_a = 1'b1;
      take_b = 1'b1;
    end else if (a_has && (!b_has || (a_exp > b_exp))) begin
      take_a = 1'b1;
    end else if (b_has) begin
      take_b = 1'b1;
    end else begin
      take_a = 1'b0;
    end
  end

  // Shared subtractor: A - B, A - 0 or 0 - B.
  assign sub_x     = take_a ? spsub_pkg::res_coef_t'(a_coef) : '0;
  assign sub_y     = take_b ? spsub_pkg::res_coef_t'(b_coef) : '0;
  assign diff      = sub_x - sub_y;
  assign res_exp   = take_a ? a_exp : b_exp;
  // Drop a zero difference only when both sides meet.
  assign res_valid = (take_a || take_b) && !(take_a && take_b && (diff == '0));

  assign slot_free = !out_valid_r || out_if.ready;

  // Load the output register at the merge end, or when a new result pushes the held one.
  assign out_load = (state_r == ST_STEP) && slot_free
                    && ((!a_has && !b_has) || (res_valid && pend_valid_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      a_cnt_r      <= '0;
      b_cnt_r      <= '0;
      ia_r         <= '0;
      ib_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (in_if.action)
              spsub_pkg::ACT_LOAD_A: begin
                if (a_we) begin
                  a_cnt_r <= a_cnt_r + 1'b1;
                end
              end
              spsub_pkg::ACT_LOAD_B: begin
                if (b_we) begin
                  b_cnt_r <= b_cnt_r + 1'b1;
                end
              end
              spsub_pkg::ACT_COMPUTE: begin
                ia_r         <= '0;
                ib_r         <= '0;
                pend_valid_r <= 1'b0;
                state_r      <= ST_FETCH;
              end
              default: begin
                // Unused code: drop it.
              end
            endcase
          end
        end
        ST_FETCH: begin
          state_r <= ST_STEP;
        end
        ST_STEP: begin
          if (slot_free) begin
            if (!a_has && !b_has) begin
              // Merge done: flush the held result as last, or report empty.
              out_last_r   <= 1'b1;
              if (pend_valid_r) begin
                out_coef_r  <= pend_coef_r;
                out_exp_r   <= pend_exp_r;
                out_empty_r <= 1'b0;
              end else begin
                out_coef_r  <= '0;
                out_exp_r   <= '0;
                out_empty_r <= 1'b1;
              end
              pend_valid_r <= 1'b0;
              a_cnt_r      <= '0;
              b_cnt_r      <= '0;
              state_r      <= ST_IDLE;
            end else begin
              if (take_a) begin
                ia_r <= ia_r + 1'b1;
              end
              if (take_b) begin
                ib_r <= ib_r + 1'b1;
              end
              if (res_valid) begin
                if (pend_valid_r) begin
                  out_coef_r  <= pend_coef_r;
                  out_exp_r   <= pend_exp_r;
                  out_last_r  <= 1'b0;
                  out_empty_r <= 1'b0;
                end
                pend_valid_r <= 1'b1;
                pend_coef_r  <= diff;
                pend_exp_r   <= res_exp;
              end
              state_r <= ST_FETCH;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_cnt_r <= CNT_W'(MAX_TERMS)) && (b_cnt_r <= CNT_W'(MAX_TERMS)))
    else $error("term count beyond capacity");

  idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> ((ia_r <= a_cnt_r) && (ib_r <= b_cnt_r)))
    else $error("merge index ran past its list");

  empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_last_r && (out_coef_r == '0)
                                      && (out_exp_r == '0)))
    else $error("empty result not zero and last");

  lists_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_STEP) && slot_free && !a_has && !b_has)
      |=> ((a_cnt_r == '0) && (b_cnt_r == '0) && out_valid_r && out_last_r))
    else $error("compute end did not clear lists or flag last");
`endif

endmodule

[sv/spsub_ram.sv]
module spsub_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sim/poly_diff_checker.sv]
`timescale 1ns / 100ps

module poly_diff_checker (
  input  logic        clk,
  input  logic        rst_n,
  spsub_in_if         in_mon,
  spsub_out_if        out_mon,
  output int unsigned mismatch_count,
  output int unsigned pending_terms,
  output int unsigned terms_seen
);
  import spsub_pkg::*;

  localparam int PRINT_LIMIT = 30;

  typedef struct packed {
    res_coef_t coef;
    exp_t      exp;
    logic      last;
    logic      empty;
  } diff_term_t;

  coef_t       a_coef [MAX_TERMS];
  exp_t        a_exp  [MAX_TERMS];
  coef_t       b_coef [MAX_TERMS];
  exp_t        b_exp  [MAX_TERMS];
  int unsigned a_len;
  int unsigned b_len;
  diff_term_t  diff_q [$];

  task automatic flag_mismatch(string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void add_term(res_coef_t c, exp_t e);
    diff_q.push_back('{coef: c, exp: e, last: 1'b0, empty: 1'b0});
  endfunction

  // Merge both lists by exponent into the expected A - B terms, then empty them.
  function automatic void merge_lists();
    int unsigned ia;
    int unsigned ib;
    int unsigned n_before;
    res_coef_t   d;
    ia = 0;
    ib = 0;
    n_before = diff_q.size();
    while (ia < a_len || ib < b_len) begin
      if (ia < a_len && ib < b_len && a_exp[ia] == b_exp[ib]) begin
        d = res_coef_t'(a_coef[ia]) - res_coef_t'(b_coef[ib]);
        if (d != 0) add_term(d, a_exp[ia]);
        ia++;
        ib++;
      end else if (ib >= b_len || (ia < a_len && a_exp[ia] > b_exp[ib])) begin
        add_term(res_coef_t'(a_coef[ia]), a_exp[ia]);
        ia++;
      end else begin
        add_term(-res_coef_t'(b_coef[ib]), b_exp[ib]);
        ib++;
      end
    end
    if (diff_q.size() == n_before)
      diff_q.push_back('{coef: '0, exp: '0, last: 1'b1, empty: 1'b1});
    else
      diff_q[diff_q.size()-1].last = 1'b1;
    a_len = 0;
    b_len = 0;
  endfunction

  always @(posedge clk) begin : watch
    diff_term_t want;
    if (!rst_n) begin
      a_len = 0;
      b_len = 0;
      diff_q.delete();
    end else begin
      // check the result side first: a term sent now belongs to an earlier compute
      if (out_mon.valid && out_mon.ready) begin
        terms_seen++;
        if (diff_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result coef %0d exp %0d",
                                  out_mon.out_coef, out_mon.out_exp));
        end else begin
          want = diff_q.pop_front();
          if (out_mon.out_coef !== want.coef)
            flag_mismatch($sformatf("out_coef got %0d want %0d (exp %0d)",
                                    out_mon.out_coef, want.coef, want.exp));
          if (out_mon.out_exp !== want.exp)
            flag_mismatch($sformatf("out_exp got %0d want %0d",
                                    out_mon.out_exp, want.exp));
          if (out_mon.out_last !== want.last)
            flag_mismatch($sformatf("out_last got %b want %b (exp %0d)",
                                    out_mon.out_last, want.last, want.exp));
          if (out_mon.out_empty !== want.empty)
            flag_mismatch($sformatf("out_empty got %b want %b",
                                    out_mon.out_empty, want.empty));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.action)
          ACT_LOAD_A: if (a_len < MAX_TERMS) begin
            a_coef[a_len] = in_mon.term_coef;
            a_exp[a_len]  = in_mon.term_exp;
            a_len++;
          end
          ACT_LOAD_B: if (b_len < MAX_TERMS) begin
            b_coef[b_len] = in_mon.term_coef;
            b_exp[b_len]  = in_mon.term_exp;
            b_len++;
          end
          ACT_COMPUTE: merge_lists();
          default: ;
        endcase
      end
    end
    pending_terms = diff_q.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import spsub_pkg::*;

  // action code the block must ignore
  localparam action_t ACT_UNUSED   = 2'd3;
  localparam int      MAX_GAP      = 17;
  localparam int      HOLD_CYCLES  = 2000;
  localparam int      DRAIN_CYCLES = 4 * MAX_TERMS + 20;
  localparam int      RANDOM_ITEMS = 110;
  localparam coef_t   COEF_MAX     = coef_t'(32767);
  localparam coef_t   COEF_MIN     = coef_t'(-32768);
  localparam exp_t    EXP_MAX      = '1;
  // which list(s) a generated exponent goes to
  localparam int      ROLE_A       = 0;
  localparam int      ROLE_B       = 1;
  localparam int      ROLE_BOTH    = 2;

  typedef struct packed {
    coef_t coef;
    exp_t  exp;
  } term_load_t;

  logic clk = 1'b0;
  logic rst_n;

  spsub_in_if  in_ch ();
  spsub_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending_terms;
  int unsigned terms_seen;
  int unsigned items_sent;
  int unsigned computes_sent;
  bit          sender_burst;
  bit          sink_burst;
  bit          hold_req;

  sparse_polynomial_subtract uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  poly_diff_checker diff_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (fail_count),
    .pending_terms  (pending_terms),
    .terms_seen     (terms_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: block stopped making progress");
    $display("Test completed with failures");
    $finish;
  end

  // Coefficients lean on the extremes and zero; the rest is full-range random.
  function automatic coef_t random_coef();
    case ($urandom_range(0, 15))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      default: return coef_t'($urandom);
    endcase
  endfunction

  function automatic exp_t random_exp();
    case ($urandom_range(0, 15))
      0:       return EXP_MAX;
      1:       return '0;
      2:       return exp_t'($urandom_range(0, 15));
      default: return exp_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the transfer.
  // Lower valid only when a gap follows, so valid never drops and rises in one step.
  task automatic send_item(action_t act, coef_t c, exp_t e);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.term_coef <= c;
    in_ch.term_exp  <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (act != ACT_UNUSED) items_sent++;
    if (act == ACT_COMPUTE) computes_sent++;
  endtask

  // One polynomial pair: n_exps distinct exponents in descending order, each
  // given to A, B or both, loads interleaved between the lists, then a compute.
  // With alternate set the exponents go A, B, A, B... so the lists never overlap.
  // A rare broken round reverses A, sprinkles ignored items and computes twice.
  task automatic run_round(int n_exps, bit alternate);
    exp_t       exps [$];
    int         idx [$];
    term_load_t a_q [$];
    term_load_t b_q [$];
    term_load_t t;
    exp_t       e;
    coef_t      c;
    int         role;
    bit         broken;
    broken = !alternate && ($urandom_range(0, 9) == 0);
    sender_burst = ($urandom_range(0, 3) == 0);
    while (exps.size() < n_exps) begin
      e = random_exp();
      idx = exps.find_first_index(x) with (x == e);
      if (idx.size() == 0) exps.push_back(e);
    end
    exps.rsort();
    foreach (exps[i]) begin
      role = alternate ? (i % 2) : $urandom_range(ROLE_A, ROLE_BOTH);
      c = random_coef();
      if (role != ROLE_B) a_q.push_back('{coef: c, exp: exps[i]});
      if (role == ROLE_B)
        b_q.push_back('{coef: c, exp: exps[i]});
      else if (role == ROLE_BOTH)
        // equal coefficients now and then, so the difference cancels
        b_q.push_back('{coef: ($urandom_range(0, 2) == 0) ? c : random_coef(),
                        exp: exps[i]});
    end
    if (broken) a_q.reverse();
    while (a_q.size() + b_q.size() > 0) begin
      if (b_q.size() == 0 || (a_q.size() > 0 && $urandom_range(0, 1) == 0)) begin
        t = a_q.pop_front();
        send_item(ACT_LOAD_A, t.coef, t.exp);
      end else begin
        t = b_q.pop_front();
        send_item(ACT_LOAD_B, t.coef, t.exp);
      end
      if (broken && $urandom_range(0, 3) == 0)
        send_item(ACT_UNUSED, random_coef(), random_exp());
    end
    send_item(ACT_COMPUTE, random_coef(), random_exp());
    if (broken) send_item(ACT_COMPUTE, random_coef(), random_exp());
  endtask

  // Result side: stall a random number of cycles before each transfer, switch
  // into and out of no-stall stretches, and take the long hold-off on request.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned base;
    int          pick;
    int          n_exps;
    // known values on every input from time zero
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_LOAD_A;
    in_ch.term_coef <= '0;
    in_ch.term_exp  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Compute on two empty lists: one empty-flag result.
    send_item(ACT_COMPUTE, '0, '0);

    // Field extremes: largest and smallest differences, lone B negated
    // (including the most negative coefficient), lone zero terms from both lists.
    send_item(ACT_LOAD_A, COEF_MAX, EXP_MAX);
    send_item(ACT_LOAD_B, COEF_MIN, EXP_MAX);
    send_item(ACT_LOAD_A, COEF_MIN, exp_t'(100));
    send_item(ACT_LOAD_B, COEF_MAX, exp_t'(100));
    send_item(ACT_LOAD_B, coef_t'(3), exp_t'(50));
    send_item(ACT_LOAD_B, COEF_MIN, exp_t'(7));
    send_item(ACT_LOAD_A, '0, exp_t'(5));
    send_item(ACT_LOAD_B, '0, exp_t'(2));
    send_item(ACT_LOAD_A, coef_t'(7), '0);
    send_item(ACT_COMPUTE, '0, '0);

    // Equal exponents that cancel leave nothing: empty-flag result.
    send_item(ACT_LOAD_A, coef_t'(123), exp_t'(9));
    send_item(ACT_LOAD_B, coef_t'(123), exp_t'(9));
    send_item(ACT_COMPUTE, '0, '0);

    // Ascending loads into A, plus an ignored action code.
    send_item(ACT_LOAD_A, coef_t'(1), exp_t'(3));
    send_item(ACT_LOAD_A, coef_t'(2), exp_t'(8));
    send_item(ACT_LOAD_B, coef_t'(5), exp_t'(5));
    send_item(ACT_UNUSED, COEF_MIN, EXP_MAX);
    send_item(ACT_COMPUTE, '0, '0);

    // Overfill both lists (two dropped loads each) with disjoint exponents for
    // the longest result burst, and hold off the result side meanwhile so the
    // merge stalls and the loads of the next round back up behind it.
    hold_req = 1'b1;
    run_round(2 * MAX_TERMS + 4, 1'b1);

    // Random rounds: mostly short polynomials, now and then empty or oversized.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        n_exps = $urandom_range(36, 60);
      else if (pick == 1)
        n_exps = 0;
      else
        n_exps = $urandom_range(1, 8);
      run_round(n_exps, 1'b0);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_terms == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items over %0d computes; %0d result terms checked.",
             items_sent, computes_sent, terms_seen);
    $display("Covered field extremes, list overflow, cancellation, unordered loads, %0s",
             "ignored codes and a long result stall.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
